// ===== src/sbsh_pkg.sv =====
// shared constants and types for the seeded byte stream hash core
package sbsh_pkg;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
    localparam int          MIX_SHIFT_A  = 30;
    localparam int          MIX_SHIFT_B  = 27;
    localparam int          MIX_SHIFT_C  = 31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_A,
        ST_WAIT_A,
        ST_MIX_B,
        ST_WAIT_B,
        ST_FINAL,
        ST_EMIT
    } hash_state_t;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_LO_LO,
        MS_LO_HI,
        MS_HI_LO
    } mul_step_t;

    typedef struct packed {
        logic        start;
        logic [63:0] op_a;
        logic [63:0] op_b;
    } mul_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] product;
    } mul_rsp_t;

endpackage

// ===== src/seeded_byte_stream_hash_core.sv =====
// top level: seeded splitmix64 finalizer hash over a byte stream
// a byte request occupies the block for two 64-bit multiplies, each on one shared 32x32
// multiplier, plus three xor-shift steps; no new request is taken until the byte is mixed
// a byteless request needs no mixing; a last request passes an emit state before the hash shows
// hash_value is held in an output register until taken; in_ready is low outside the idle state
// reset (rst_n, async, active low) clears the seed, the open-message flag and all handshakes
module seeded_byte_stream_hash_core
    import sbsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [63:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        no_byte,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] hash_value
);

    hash_state_t state_reg, state_next;
    logic [63:0] seed_reg, seed_next;
    logic        in_msg_reg, in_msg_next;
    logic        last_reg, last_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] hash_reg, hash_next;
    logic [63:0] out_hash_reg, out_hash_next;
    logic [63:0] base_hash;
    logic [63:0] gamma_sum;
    logic        accept;
    mul_req_t    mul_req;
    mul_rsp_t    mul_rsp;

    sbsh_mul64 u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= 64'd0;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            in_msg_reg    <= in_msg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg     <= last_next;
        hash_reg     <= hash_next;
        out_hash_reg <= out_hash_next;
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign hash_value = out_hash_reg;
    assign base_hash  = in_msg_reg ? hash_reg : (seed_reg + GOLDEN_GAMMA);
    assign gamma_sum  = hash_reg + GOLDEN_GAMMA;

    always_comb
    begin
        state_next     = state_reg;
        seed_next      = cfg_wr_en ? cfg_wr_data : seed_reg;
        in_msg_next    = in_msg_reg;
        last_next      = last_reg;
        hash_next      = hash_reg;
        out_hash_next  = out_hash_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mul_req.start  = 1'b0;
        mul_req.op_a   = hash_reg;
        mul_req.op_b   = MIX_MUL_A;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    in_msg_next = 1'b1;
                    last_next   = last_item;
                    if (no_byte)
                    begin
                        hash_next = base_hash;
                        if (last_item)
                            state_next = ST_EMIT;
                    end
                    else
                    begin
                        hash_next  = base_hash ^ {56'd0, data_byte};
                        state_next = ST_MIX_A;
                    end
                end
            end
            ST_MIX_A:
            begin
                mul_req.start = 1'b1;
                mul_req.op_a  = gamma_sum ^ (gamma_sum >> MIX_SHIFT_A);
                mul_req.op_b  = MIX_MUL_A;
                state_next    = ST_WAIT_A;
            end
            ST_WAIT_A:
            begin
                if (mul_rsp.done)
                begin
                    hash_next  = mul_rsp.product;
                    state_next = ST_MIX_B;
                end
            end
            ST_MIX_B:
            begin
                mul_req.start = 1'b1;
                mul_req.op_a  = hash_reg ^ (hash_reg >> MIX_SHIFT_B);
                mul_req.op_b  = MIX_MUL_B;
                state_next    = ST_WAIT_B;
            end
            ST_WAIT_B:
            begin
                if (mul_rsp.done)
                begin
                    hash_next  = mul_rsp.product;
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                hash_next  = hash_reg ^ (hash_reg >> MIX_SHIFT_C);
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_hash_next  = hash_reg;
                    out_valid_next = 1'b1;
                    in_msg_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // multiplier only runs while a byte is being mixed
    a_mul_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !mul_rsp.busy)
        else $error("multiplier busy while accepting requests");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == ST_WAIT_A || state_reg == ST_WAIT_B))
        else $error("multiplier result outside a wait state");

    a_emit_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> last_reg)
        else $error("emit without a last request");

    a_result_closes_msg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && (!out_valid_reg || out_ready)) |=> (out_valid && !in_msg_reg))
        else $error("emitted hash did not close the message");

endmodule

// ===== src/sbsh_mul64.sv =====
// iterative 64x64 multiplier, low 64 bits of the product, one shared 32x32 multiplier
module sbsh_mul64
    import sbsh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    mul_step_t   step_reg, step_next;
    logic        done_reg, done_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= MS_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_x = a_reg[31:0];
        mul_y = b_reg[31:0];
        case (step_reg)
            MS_LO_HI: mul_y = b_reg[63:32];
            MS_HI_LO: mul_x = a_reg[63:32];
            default:  ;
        endcase
    end

    assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

    always_comb
    begin
        step_next = step_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        case (step_reg)
            MS_IDLE:
            begin
                if (req.start)
                begin
                    a_next    = req.op_a;
                    b_next    = req.op_b;
                    step_next = MS_LO_LO;
                end
            end
            MS_LO_LO:
            begin
                acc_next  = mul_p;
                step_next = MS_LO_HI;
            end
            MS_LO_HI:
            begin
                acc_next  = acc_reg + {mul_p[31:0], 32'd0};
                step_next = MS_HI_LO;
            end
            MS_HI_LO:
            begin
                acc_next  = acc_reg + {mul_p[31:0], 32'd0};
                done_next = 1'b1;
                step_next = MS_IDLE;
            end
            default: step_next = MS_IDLE;
        endcase
    end

    assign rsp.busy    = (step_reg != MS_IDLE);
    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// ===== verif/tb_seeded_byte_stream_hash_core.sv =====
// testbench for the seeded byte stream hash core: table-driven and random messages
module tb_seeded_byte_stream_hash_core;
    import sbsh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_LIMIT = 24;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 84;

    typedef struct packed {
        logic        wr_seed;
        logic [63:0] seed;
        logic [7:0]  byte_val;
        logic        empty;
        logic        last;
        logic        pinned;
        logic [63:0] hash;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [63:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        no_byte = 1'b0;
    logic        last_item = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] hash_value;

    logic        pin_on = 1'b0;
    logic [63:0] pin_hash = '0;
    logic        idle_on = 1'b1;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    int          fail_cnt = 0;

    logic [63:0] model_seed = '0;
    logic [63:0] model_hash = '0;
    logic        model_open = 1'b0;
    logic [63:0] pending_hashes [$];

    stim_row_t dir_rows [20] = '{
        '{1'b0, 64'h0, 8'h00, 1'b1, 1'b1, 1'b1, GOLDEN_GAMMA},
        '{1'b0, 64'h0, 8'h00, 1'b0, 1'b1, 1'b0, 64'h0},
        '{1'b0, 64'h0, 8'hFF, 1'b0, 1'b1, 1'b0, 64'h0},
        '{1'b0, 64'h0, 8'hA5, 1'b0, 1'b0, 1'b0, 64'h0},
        '{1'b0, 64'h0, 8'h5A, 1'b0, 1'b0, 1'b0, 64'h0},
        '{1'b0, 64'h0, 8'hC3, 1'b1, 1'b0, 1'b0, 64'h0},
        '{1'b0, 64'h0, 8'h3C, 1'b0, 1'b1, 1'b0, 64'h0},
        '{1'b0, 64'h0, 8'h96, 1'b1, 1'b0, 1'b0, 64'h0},
        '{1'b0, 64'h0, 8'h01, 1'b0, 1'b1, 1'b0, 64'h0},
        '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b1, 1'b1, 1'b1, 64'h9E37_79B9_7F4A_7C14},
        '{1'b0, 64'h0, 8'hFF, 1'b0, 1'b1, 1'b0, 64'h0},
        '{1'b1, 64'h0123_4567_89AB_CDEF, 8'h80, 1'b0, 1'b0, 1'b0, 64'h0},
        '{1'b1, 64'h0, 8'h7F, 1'b0, 1'b1, 1'b0, 64'h0},
        '{1'b0, 64'h0, 8'h00, 1'b1, 1'b1, 1'b1, GOLDEN_GAMMA},
        '{1'b1, 64'h61C8_8646_80B5_83EB, 8'h00, 1'b1, 1'b1, 1'b1, 64'h0},
        '{1'b0, 64'h0, 8'h11, 1'b0, 1'b0, 1'b0, 64'h0},
        '{1'b0, 64'h0, 8'hEE, 1'b1, 1'b1, 1'b0, 64'h0},
        '{1'b0, 64'h0, 8'h00, 1'b0, 1'b0, 1'b0, 64'h0},
        '{1'b0, 64'h0, 8'hFF, 1'b0, 1'b0, 1'b0, 64'h0},
        '{1'b0, 64'h0, 8'h55, 1'b0, 1'b1, 1'b0, 64'h0}
    };

    seeded_byte_stream_hash_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .no_byte     (no_byte),
        .last_item   (last_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hash_value  (hash_value)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [63:0] splitmix_finish(input logic [63:0] v);
        logic [63:0] x;
        x = v + GOLDEN_GAMMA;
        x = (x ^ (x >> MIX_SHIFT_A)) * MIX_MUL_A;
        x = (x ^ (x >> MIX_SHIFT_B)) * MIX_MUL_B;
        return x ^ (x >> MIX_SHIFT_C);
    endfunction

    // predict on every accepted request
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            if (!model_open)
            begin
                model_hash = model_seed + GOLDEN_GAMMA;
                model_open = 1'b1;
            end
            if (!no_byte)
                model_hash = splitmix_finish(model_hash ^ {56'h0, data_byte});
            if (last_item)
            begin
                pending_hashes.push_back(pin_on ? pin_hash : model_hash);
                model_open = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_hashes.size() == 0)
            begin
                $error("hash_value: expected none, actual %h", hash_value);
                fail_cnt++;
            end
            else
            begin
                if (hash_value !== pending_hashes[0])
                begin
                    $error("hash_value: expected %h, actual %h", pending_hashes[0], hash_value);
                    fail_cnt++;
                end
                void'(pending_hashes.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [7:0] b, input logic empty, input logic last,
                                input logic pinned, input logic [63:0] hash);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        no_byte   <= empty;
        last_item <= last;
        pin_on    <= pinned;
        pin_hash  <= hash;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // drain results and let any byte still mixing finish before the write
    task automatic write_seed(input logic [63:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_seed = v;
    endtask

    initial
    begin
        int          sent;
        int          msg_len;
        logic        empty_close;
        logic [63:0] phase_seed;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].wr_seed)
                write_seed(dir_rows[i].seed);
            send_request(dir_rows[i].byte_val, dir_rows[i].empty, dir_rows[i].last,
                         dir_rows[i].pinned, dir_rows[i].hash);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                1:       phase_seed = '1;
                2:       phase_seed = '0;
                4:       phase_seed = 64'h61C8_8646_80B5_83EB;
                default: phase_seed = {$urandom, $urandom};
            endcase
            write_seed(phase_seed);
            if (p == PHASES - 1)
                idle_on = 1'b0;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                      : $urandom_range(0, 6);
                empty_close = (msg_len == 0) || ($urandom_range(0, 4) == 0);
                for (int k = 0; k < msg_len; k++)
                begin
                    if (k != 0 && $urandom_range(0, 39) == 0)
                        write_seed({$urandom, $urandom});
                    if ($urandom_range(0, 7) == 0)
                    begin
                        send_request(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, '0);
                        sent++;
                    end
                    send_request(8'($urandom_range(0, 255)), 1'b0,
                                 !empty_close && (k == msg_len - 1), 1'b0, '0);
                    sent++;
                end
                if (empty_close)
                begin
                    send_request(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0, '0);
                    sent++;
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_LIMIT) @(posedge clk);
        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
